// ----- src/rv32i_lite_retire_checker_macros.svh -----
// ----------------------------------------------------------------------------
// rv32i_lite_retire_checker_macros
// assertion macros shared by the retire checker rtl
// ----------------------------------------------------------------------------
`ifndef RV32I_LITE_RETIRE_CHECKER_MACROS_SVH
`define RV32I_LITE_RETIRE_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
// checked only while rst is low
`define RVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define RVC_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVC_ASSERT(label, prop, msg)
`define RVC_ASSERT_ANY(label, prop, msg)
`endif
`endif

// ----- src/rvc_pkg.sv -----
// ----------------------------------------------------------------------------
// rvc_pkg
// types, opcodes and decode helpers for the rv32i lite retire checker
// ----------------------------------------------------------------------------
`default_nettype none

package rvc_pkg;

  localparam int NREGS = 32;

  typedef logic [31:0] word_t;
  typedef logic [4:0]  reg_idx_t;

  localparam logic [6:0] OP_REG    = 7'd51;
  localparam logic [6:0] OP_IMM    = 7'd19;
  localparam logic [6:0] OP_LOAD   = 7'd3;
  localparam logic [6:0] OP_STORE  = 7'd35;
  localparam logic [6:0] OP_BRANCH = 7'd99;

  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_ALT  = 7'd32;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BEQ  = 3'd0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PC    = 2'd1,
    ST_UNSUP = 2'd2,
    ST_ADDR  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OPK_ADD,
    OPK_SUB,
    OPK_AND,
    OPK_OR,
    OPK_ADDI,
    OPK_LW,
    OPK_SW,
    OPK_BEQ,
    OPK_BAD
  } op_t;

  typedef struct packed {
    logic     en;
    reg_idx_t addr;
    word_t    data;
  } rf_wr_t;

  function automatic word_t sext12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic word_t branch_off(word_t ins);
    return {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  endfunction

  function automatic op_t decode(word_t ins);
    op_t        op;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    opc = ins[6:0];
    f3  = ins[14:12];
    f7  = ins[31:25];
    op  = OPK_BAD;
    case (opc)
      OP_REG: begin
        if (f3 == F3_ADD && f7 == F7_BASE) op = OPK_ADD;
        else if (f3 == F3_ADD && f7 == F7_ALT) op = OPK_SUB;
        else if (f3 == F3_AND && f7 == F7_BASE) op = OPK_AND;
        else if (f3 == F3_OR && f7 == F7_BASE) op = OPK_OR;
      end
      OP_IMM: begin
        if (f3 == F3_ADD) op = OPK_ADDI;
      end
      OP_LOAD: begin
        if (f3 == F3_WORD) op = OPK_LW;
      end
      OP_STORE: begin
        if (f3 == F3_WORD) op = OPK_SW;
      end
      OP_BRANCH: begin
        if (f3 == F3_BEQ) op = OPK_BEQ;
      end
      default: op = OPK_BAD;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ----- src/rvc_retire_if.sv -----
// ----------------------------------------------------------------------------
// rvc_retire_if
// retired instruction channel: pc and instruction word
// ----------------------------------------------------------------------------
`default_nettype none

interface rvc_retire_if;
  import rvc_pkg::*;

  logic  valid;
  logic  ready;
  word_t retired_pc;
  word_t instruction;

  modport source (output valid, retired_pc, instruction, input ready);
  modport sink   (input valid, retired_pc, instruction, output ready);
endinterface

`default_nettype wire

// ----- src/rvc_report_if.sv -----
// ----------------------------------------------------------------------------
// rvc_report_if
// result channel: status, expected register and memory writes, count
// ----------------------------------------------------------------------------
`default_nettype none

interface rvc_report_if;
  import rvc_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       reg_write;
  reg_idx_t   dest_reg;
  word_t      reg_value;
  logic       mem_write;
  logic [7:0] mem_addr;
  word_t      mem_data;
  word_t      retired_count;

  modport source (output valid, status, reg_write, dest_reg, reg_value, mem_write,
                  mem_addr, mem_data, retired_count, input ready);
  modport sink   (input valid, status, reg_write, dest_reg, reg_value, mem_write,
                  mem_addr, mem_data, retired_count, output ready);
endinterface

`default_nettype wire

// ----- src/rvc_regfile.sv -----
// ----------------------------------------------------------------------------
// rvc_regfile
// 32 x 32 register file memory, two registered read ports, one write port
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_regfile (
  input  logic             clk,
  input  logic             rd_en,
  input  rvc_pkg::reg_idx_t rs1,
  input  rvc_pkg::reg_idx_t rs2,
  output rvc_pkg::word_t   rdata1,
  output rvc_pkg::word_t   rdata2,
  input  rvc_pkg::rf_wr_t  wr
);
  import rvc_pkg::*;

  word_t mem [NREGS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    // read before write on a same-address collision
    if (rd_en) begin
      rdata1 <= mem[rs1];
      rdata2 <= mem[rs2];
    end
  end

endmodule

`default_nettype wire

// ----- src/rvc_dmem.sv -----
// ----------------------------------------------------------------------------
// rvc_dmem
// word data memory, single port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_dmem #(
  parameter int DMEM_WORDS = 64,
  localparam int DMEM_AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic               we,
  input  logic [DMEM_AW-1:0] addr,
  input  rvc_pkg::word_t     wdata,
  output rvc_pkg::word_t     rdata
);
  import rvc_pkg::*;

  word_t mem [DMEM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/rv32i_lite_retire_checker.sv -----
// ----------------------------------------------------------------------------
// rv32i_lite_retire_checker
// lockstep checker for retired rv32i subset instructions
// ----------------------------------------------------------------------------
// The retire channel takes the pc and instruction word of each retired
// instruction. For every transfer the report channel returns one result:
// status, the expected register write, the expected store and the count of
// instructions retired without error.
// From the retire transfer each item passes the register file read, then execute
// with data memory access, then load writeback into the output register, where
// report valid rises; the report can transfer on the next edge.
// Throughput is one instruction per cycle while the report side does not stall;
// results of older instructions are forwarded from the writeback stage so dependent instructions do not wait.
// After reset the register file and data memory are swept to zero, one entry
// per cycle, over max(DMEM_WORDS, 32) entries; retire.ready stays low meanwhile.
// When the report side stalls, the whole pipeline holds and retire.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rv32i_lite_retire_checker_macros.svh"

module rv32i_lite_retire_checker #(
  parameter int DMEM_WORDS = 64
) (
  input  logic clk,
  input  logic rst,
  rvc_retire_if.sink   retire,
  rvc_report_if.source report
);
  import rvc_pkg::*;

  localparam int DMEM_AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
  localparam int CLR_N = (DMEM_WORDS > NREGS) ? DMEM_WORDS : NREGS;
  localparam int CLR_W = $clog2(CLR_N);
  localparam word_t DMEM_BYTES = 32'(4 * DMEM_WORDS);

  // clear sweep
  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLR_W'(CLR_N - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  logic adv;
  logic acc;

  assign adv          = !report.valid || report.ready;
  assign retire.ready = adv && !clearing;
  assign acc          = retire.valid && retire.ready;

  // execute stage
  logic  b_valid;
  word_t b_pc;
  word_t b_ins;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pc  <= retire.retired_pc;
      b_ins <= retire.instruction;
    end
  end

  word_t  rf_a;
  word_t  rf_b;
  rf_wr_t rf_wr;

  rvc_regfile u_regfile (
    .clk    (clk),
    .rd_en  (adv),
    .rs1    (retire.instruction[19:15]),
    .rs2    (retire.instruction[24:20]),
    .rdata1 (rf_a),
    .rdata2 (rf_b),
    .wr     (rf_wr)
  );

  // writeback stage
  logic       c_valid;
  logic [1:0] c_status;
  logic       c_we;
  reg_idx_t   c_rd;
  word_t      c_val;
  logic       c_load;
  logic       c_mw;
  logic [7:0] c_maddr;
  word_t      c_mdata;
  word_t      c_count;
  word_t      c_fwd_val;
  word_t      dmem_rdata;

  // write that landed on the edge at which the execute item read the file
  logic     wb_en;
  reg_idx_t wb_rd;
  word_t    wb_val;

  assign c_fwd_val = c_load ? dmem_rdata : c_val;

  reg_idx_t b_rd;
  reg_idx_t b_rs1;
  reg_idx_t b_rs2;
  op_t      b_op;
  word_t    a;
  word_t    b;
  word_t    imm_i;
  word_t    ea;
  logic     addr_ok;
  status_t  b_status;
  logic     b_ok;
  logic     b_mem_op;
  logic     b_reg_op;
  logic     b_we;
  word_t    b_val;
  word_t    expected_pc;
  word_t    expected_pc_next;
  word_t    retire_count;
  word_t    retire_count_next;

  always_comb begin
    b_rd  = b_ins[11:7];
    b_rs1 = b_ins[19:15];
    b_rs2 = b_ins[24:20];
    b_op  = decode(b_ins);

    if (c_valid && c_we && c_rd == b_rs1) a = c_fwd_val;
    else if (wb_en && wb_rd == b_rs1) a = wb_val;
    else a = rf_a;

    if (c_valid && c_we && c_rd == b_rs2) b = c_fwd_val;
    else if (wb_en && wb_rd == b_rs2) b = wb_val;
    else b = rf_b;

    imm_i = sext12(b_ins[31:20]);
    if (b_op == OPK_SW) ea = a + sext12({b_ins[31:25], b_ins[11:7]});
    else ea = a + imm_i;
    addr_ok  = (ea < DMEM_BYTES) && (ea[1:0] == 2'b00);
    b_mem_op = (b_op == OPK_LW) || (b_op == OPK_SW);

    if (b_pc != expected_pc) b_status = ST_PC;
    else if (b_op == OPK_BAD) b_status = ST_UNSUP;
    else if (b_mem_op && !addr_ok) b_status = ST_ADDR;
    else b_status = ST_OK;
    b_ok = (b_status == ST_OK);

    case (b_op)
      OPK_ADD:  b_val = a + b;
      OPK_SUB:  b_val = a - b;
      OPK_AND:  b_val = a & b;
      OPK_OR:   b_val = a | b;
      OPK_ADDI: b_val = a + imm_i;
      default:  b_val = '0;
    endcase
    if (!b_ok) b_val = '0;

    b_reg_op = b_ok && (b_op != OPK_SW) && (b_op != OPK_BEQ) && (b_op != OPK_BAD);
    b_we     = b_reg_op && (b_rd != '0);

    if (b_op == OPK_BEQ && a == b) expected_pc_next = b_pc + branch_off(b_ins);
    else expected_pc_next = b_pc + 32'd4;
    retire_count_next = retire_count + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_pc  <= '0;
      retire_count <= '0;
    end else if (adv && b_valid && b_ok) begin
      expected_pc  <= expected_pc_next;
      retire_count <= retire_count_next;
    end
  end

  // data memory: clear sweep or execute-stage access
  logic               dmem_we;
  logic [DMEM_AW-1:0] dmem_addr;
  word_t              dmem_wdata;

  always_comb begin
    if (clearing) begin
      dmem_we    = {1'b0, clr_cnt} < (CLR_W + 1)'(DMEM_WORDS);
      dmem_addr  = clr_cnt[DMEM_AW-1:0];
      dmem_wdata = '0;
    end else begin
      dmem_we    = adv && b_valid && b_ok && (b_op == OPK_SW);
      dmem_addr  = ea[DMEM_AW+1:2];
      dmem_wdata = b;
    end
  end

  rvc_dmem #(
    .DMEM_WORDS (DMEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .rd_en (adv),
    .we    (dmem_we),
    .addr  (dmem_addr),
    .wdata (dmem_wdata),
    .rdata (dmem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_status <= b_status;
      c_we     <= b_we;
      c_rd     <= b_reg_op ? b_rd : '0;
      c_val    <= b_val;
      c_load   <= b_ok && (b_op == OPK_LW);
      c_mw     <= b_ok && (b_op == OPK_SW);
      c_maddr  <= (b_ok && b_mem_op) ? ea[7:0] : '0;
      c_mdata  <= (b_ok && (b_op == OPK_SW)) ? b : '0;
      c_count  <= b_ok ? retire_count_next : retire_count;
    end
  end

  always_comb begin
    if (clearing) begin
      rf_wr.en   = {1'b0, clr_cnt} < (CLR_W + 1)'(NREGS);
      rf_wr.addr = clr_cnt[4:0];
      rf_wr.data = '0;
    end else begin
      rf_wr.en   = adv && c_valid && c_we;
      rf_wr.addr = c_rd;
      rf_wr.data = c_fwd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_en <= 1'b0;
    end else if (adv) begin
      wb_en <= c_valid && c_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wb_rd  <= c_rd;
      wb_val <= c_fwd_val;
    end
  end

  // output register
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      report.status        <= c_status;
      report.reg_write     <= c_we;
      report.dest_reg      <= c_rd;
      report.reg_value     <= c_fwd_val;
      report.mem_write     <= c_mw;
      report.mem_addr      <= c_maddr;
      report.mem_data      <= c_mdata;
      report.retired_count <= c_count;
    end
  end

  assign report.valid = out_valid;

  `RVC_ASSERT(a_idle_while_clearing, clearing |-> !b_valid && !c_valid && !report.valid, "pipeline busy during clear sweep")
  `RVC_ASSERT(a_error_no_writes, report.valid && report.status != ST_OK |-> !report.reg_write && !report.mem_write, "error result carries a write")
  `RVC_ASSERT(a_count_step, adv && b_valid && b_ok |=> retire_count == $past(retire_count) + 32'd1, "retire count did not advance by one")
  `RVC_ASSERT(a_no_x0_write, rf_wr.en && !clearing |-> rf_wr.addr != '0, "register file write to x0")
  `RVC_ASSERT_ANY(a_reset_flush, rst |=> !report.valid && !c_valid && !b_valid, "pipeline not flushed by reset")

endmodule

`default_nettype wire
